[src/svo_pkg.sv]
// ----------------------------------------------------------------------------
// svo_pkg
// Shared types and constants for the segment address-to-offset lookup.
// ----------------------------------------------------------------------------
package svo_pkg;

  localparam int NUM_SEGMENTS = 16;
  localparam int SEG_ADDR_W   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int CFG_W        = 5;
  localparam int SEG_IDX_W    = 4;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_t;

  typedef struct packed {
    action_t               action;
    logic [SEG_IDX_W-1:0]  entry_index;
    logic [31:0]           seg_vaddr;
    logic [31:0]           seg_filesz;
    logic [31:0]           seg_offset;
    logic [31:0]           lookup_vaddr;
    logic [31:0]           span;
  } in_word_t;

  typedef struct packed {
    logic                  found;
    logic [SEG_IDX_W-1:0]  seg_index;
    logic [31:0]           file_offset;
    logic [31:0]           room;
  } out_word_t;

  // One table row as stored in the RAM
  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] fileoff;
  } seg_entry_t;

  localparam int ENTRY_W = $bits(seg_entry_t);

  // Lookup request handed from the top level to the scan sequencer
  typedef struct packed {
    logic                  start;
    logic [31:0]           addr;
    logic [31:0]           need;
    logic [SEG_ADDR_W-1:0] last_k;
    logic                  none;
  } lookup_req_t;

endpackage

[src/svo_ram.sv]
// ----------------------------------------------------------------------------
// svo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/svo_scan.sv]
// ----------------------------------------------------------------------------
// svo_scan
// Lookup sequencer: walks the table one entry per cycle unless the output
// stalls, checks each against address and span, registers first hit or miss.
// ----------------------------------------------------------------------------
module svo_scan (
  input  logic                           clk,
  input  logic                           rst,
  input  svo_pkg::lookup_req_t           req,
  input  svo_pkg::seg_entry_t            ent,
  output logic [svo_pkg::SEG_ADDR_W-1:0] raddr,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output svo_pkg::out_word_t             out_word
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                         state;
  logic [svo_pkg::SEG_ADDR_W-1:0] chk_k;
  logic [svo_pkg::SEG_ADDR_W-1:0] last_k;
  logic                           none;
  logic [31:0]                    addr;
  logic [31:0]                    need;

  logic        frozen;
  logic [31:0] gap;
  logic [31:0] left;
  logic        hit;
  logic        done;

  // Hold the scan while the previous word still sits in the output register
  assign frozen = out_valid && out_stall;

  assign gap  = addr - ent.base;
  assign left = ent.size - gap;
  assign hit  = (addr >= ent.base) && (ent.size >= gap) && (left >= need);
  assign done = none || hit || (chk_k == last_k);

  assign busy = (state == S_SCAN);

  // Entry chk_k is on the RAM output; prefetch the next one unless frozen
  always_comb begin
    case (state)
      S_IDLE:  raddr = '0;
      S_SCAN:  raddr = frozen ? chk_k : svo_pkg::SEG_ADDR_W'(chk_k + 1'b1);
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Raise on a finished scan, drop once the held word is taken
      if ((state == S_SCAN) && !frozen && done) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.start) begin
            addr   <= req.addr;
            need   <= req.need;
            last_k <= req.last_k;
            none   <= req.none;
            chk_k  <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!frozen) begin
            if (done) begin
              if (hit && !none) begin
                out_word.found       <= 1'b1;
                out_word.seg_index   <= svo_pkg::SEG_IDX_W'(chk_k);
                out_word.file_offset <= ent.fileoff + gap;
                out_word.room        <= left;
              end else begin
                out_word <= '0;
              end
              state <= S_IDLE;
            end else begin
              chk_k <= svo_pkg::SEG_ADDR_W'(chk_k + 1'b1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/segment_vaddr_to_offset_lookup.sv]
// ----------------------------------------------------------------------------
// segment_vaddr_to_offset_lookup
// Segment table with virtual-address to file-offset translation.
// ----------------------------------------------------------------------------
// A load word writes one table entry (base, file size, file offset) and
// returns nothing. A lookup word scans the active entries in index order,
// one entry per cycle through the single read port of the table RAM, and
// returns the first entry that covers the address and span, or a miss.
// The number of entries examined runs up to and including the first hit,
// at most count (active_segments capped at the table depth) and at least
// one even when count is zero. The scan waits while the previous result is
// still stalled in the output register. in_stall is high for the length of
// a scan. Entries read before they were ever loaded give undefined fields.
// active_segments is written through cfg_we/cfg_data and must only change
// while idle.
// ----------------------------------------------------------------------------
module segment_vaddr_to_offset_lookup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [svo_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  svo_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output svo_pkg::out_word_t        out_word
);

  logic [svo_pkg::CFG_W-1:0]      active_segments;
  logic                           in_accept;
  logic                           ram_we;
  logic [svo_pkg::SEG_ADDR_W-1:0] ram_raddr;
  svo_pkg::seg_entry_t            wr_entry;
  svo_pkg::seg_entry_t            rd_entry;
  svo_pkg::lookup_req_t           req;
  int unsigned                    cnt;
  logic                           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_segments <= '0;
    end else if (cfg_we) begin
      active_segments <= cfg_data;
    end
  end

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  // Drop loads aimed past the end of the table
  assign ram_we = in_accept && (in_word.action == svo_pkg::ACT_LOAD) &&
                  (int'(in_word.entry_index) < svo_pkg::NUM_SEGMENTS);

  assign wr_entry.base    = in_word.seg_vaddr;
  assign wr_entry.size    = in_word.seg_filesz;
  assign wr_entry.fileoff = in_word.seg_offset;

  always_comb begin
    cnt = (int'(active_segments) > svo_pkg::NUM_SEGMENTS) ?
          svo_pkg::NUM_SEGMENTS : int'(active_segments);
    req.start  = in_accept && (in_word.action == svo_pkg::ACT_LOOKUP);
    req.addr   = in_word.lookup_vaddr;
    req.need   = in_word.span;
    req.none   = (cnt == 0);
    req.last_k = svo_pkg::SEG_ADDR_W'(cnt - 1);
  end

  svo_ram #(
    .WIDTH (svo_pkg::ENTRY_W),
    .DEPTH (svo_pkg::NUM_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (svo_pkg::SEG_ADDR_W'(in_word.entry_index)),
    .wdata (wr_entry),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  svo_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ent       (rd_entry),
    .raddr     (ram_raddr),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

[src/svo_checker.sv]
// ----------------------------------------------------------------------------
// svo_checker
// Port-level assertions for the segment lookup, bound to the top level.
// ----------------------------------------------------------------------------
module svo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input svo_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input svo_pkg::out_word_t out_word
);

  // A stalled result word stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // A lookup occupies the block for at least the next cycle
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_word.action == svo_pkg::ACT_LOOKUP |=> in_stall)
    else $error("input accepted right after a lookup");

  // A load never produces a result word
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    !out_valid && in_valid && !in_stall && in_word.action == svo_pkg::ACT_LOAD
    |=> !out_valid)
    else $error("result word after a load");

  // A miss carries all-zero fields
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.found |->
      out_word.seg_index == '0 && out_word.file_offset == '0 && out_word.room == '0)
    else $error("miss with nonzero fields");

endmodule

bind segment_vaddr_to_offset_lookup svo_checker u_svo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

[tb/svo_checker.sv]
// ----------------------------------------------------------------------------
// svo_scoreboard
// Watches the config port and both word channels of the segment lookup,
// keeps its own copy of the segment table and the active count, predicts the
// translation of every accepted lookup word and compares each result word
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module svo_scoreboard
  import svo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  output int                   errors,
  output int                   pending,
  output int                   hits,
  output int                   misses
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0]      seg_base [NUM_SEGMENTS];
  logic [31:0]      seg_size [NUM_SEGMENTS];
  logic [31:0]      seg_foff [NUM_SEGMENTS];
  logic [CFG_W-1:0] active_cnt;

  out_word_t translations_due[$];
  int        fail_cnt;
  int        hit_cnt;
  int        miss_cnt;

  initial begin
    errors  = 0;
    pending = 0;
    hits    = 0;
    misses  = 0;
  end

  // First active entry that covers addr and need bytes beyond it
  function automatic out_word_t translate(logic [31:0] addr, logic [31:0] need);
    out_word_t   res;
    int unsigned lim;
    logic [31:0] gap;
    res = '0;
    lim = (active_cnt > NUM_SEGMENTS) ? NUM_SEGMENTS : active_cnt;
    for (int k = 0; k < lim; k++) begin
      gap = addr - seg_base[k];
      if (addr >= seg_base[k] && seg_size[k] >= gap && seg_size[k] - gap >= need) begin
        res.found       = 1'b1;
        res.seg_index   = k[SEG_IDX_W-1:0];
        res.file_offset = seg_foff[k] + gap;
        res.room        = seg_size[k] - gap;
        return res;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      active_cnt = '0;
      translations_due.delete();
      fail_cnt = 0;
      hit_cnt  = 0;
      miss_cnt = 0;
    end else begin
      if (cfg_we)
        active_cnt = cfg_data;
      if (in_valid && !in_stall) begin
        if (in_word.action == ACT_LOAD) begin
          if (in_word.entry_index < NUM_SEGMENTS) begin
            seg_base[in_word.entry_index] = in_word.seg_vaddr;
            seg_size[in_word.entry_index] = in_word.seg_filesz;
            seg_foff[in_word.entry_index] = in_word.seg_offset;
          end
        end else begin
          translations_due.push_back(translate(in_word.lookup_vaddr, in_word.span));
        end
      end
      if (out_valid && !out_stall) begin
        if (translations_due.size() == 0) begin
          $error("result word with no lookup outstanding");
          fail_cnt++;
        end else begin
          want = translations_due.pop_front();
          if (want.found)
            hit_cnt++;
          else
            miss_cnt++;
          if (out_word.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_word.found);
            fail_cnt++;
          end
          if (out_word.seg_index !== want.seg_index) begin
            $error("seg_index: expected %0d, got %0d", want.seg_index, out_word.seg_index);
            fail_cnt++;
          end
          if (out_word.file_offset !== want.file_offset) begin
            $error("file_offset: expected %h, got %h", want.file_offset,
                   out_word.file_offset);
            fail_cnt++;
          end
          if (out_word.room !== want.room) begin
            $error("room: expected %h, got %h", want.room, out_word.room);
            fail_cnt++;
          end
        end
      end
    end
    errors  <= fail_cnt;
    pending <= translations_due.size();
    hits    <= hit_cnt;
    misses  <= miss_cnt;
  end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the segment address-to-offset lookup. Loads the
// whole table, runs directed lookups on boundaries, then random phases under
// different active counts with mostly well-aimed lookups and random stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import svo_pkg::*;

  localparam int TOTAL_WORDS = 1950;
  localparam int CALM_AFTER  = 1750;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE      = 24;

  logic             clk;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  in_word_t         in_word   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_word_t        out_word;

  int errors;
  int pending;
  int hits;
  int misses;

  // stimulus-side view of the table, used only to aim lookups
  logic [31:0]      base_shadow [NUM_SEGMENTS];
  logic [31:0]      size_shadow [NUM_SEGMENTS];
  logic [CFG_W-1:0] active_shadow;
  int               words_sent;
  int               settings;
  bit               calm = 1'b0;
  int               quiet;
  int               hold_cnt;
  bit               hold_on;

  segment_vaddr_to_offset_lookup DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  svo_scoreboard u_scoreboard (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .errors    (errors),
    .pending   (pending),
    .hits      (hits),
    .misses    (misses)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall bursts and free runs of random length in random order
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cnt = 0;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_cnt == 0) begin
        hold_on = ($urandom_range(0, 2) == 0);
        if (hold_on)
          hold_cnt = $urandom_range(1, 9);
        else if ($urandom_range(0, 7) == 0)
          hold_cnt = $urandom_range(50, 150);
        else
          hold_cnt = $urandom_range(1, 24);
      end
      out_stall <= hold_on;
      hold_cnt--;
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Uniform value in [0, top_val]
  function automatic logic [31:0] pick_upto(logic [31:0] top_val);
    logic [63:0] r;
    r = {$urandom, $urandom} % ({32'd0, top_val} + 64'd1);
    return r[31:0];
  endfunction

  function automatic in_word_t noise_word();
    in_word_t w;
    w.action       = ($urandom_range(0, 1) == 0) ? ACT_LOAD : ACT_LOOKUP;
    w.entry_index  = SEG_IDX_W'($urandom_range(0, NUM_SEGMENTS - 1));
    w.seg_vaddr    = $urandom;
    w.seg_filesz   = $urandom;
    w.seg_offset   = $urandom;
    w.lookup_vaddr = $urandom;
    w.span         = $urandom;
    return w;
  endfunction

  // Called at a clock edge; returns at the edge that accepts the word
  task automatic send(in_word_t w);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent >= CALM_AFTER)
      calm = 1'b1;
  endtask

  task automatic load_entry(int idx, logic [31:0] base, logic [31:0] size,
                            logic [31:0] foff);
    in_word_t w;
    w = noise_word();
    w.action      = ACT_LOAD;
    w.entry_index = SEG_IDX_W'(idx);
    w.seg_vaddr   = base;
    w.seg_filesz  = size;
    w.seg_offset  = foff;
    base_shadow[idx] = base;
    size_shadow[idx] = size;
    send(w);
  endtask

  task automatic lookup(logic [31:0] addr, logic [31:0] need);
    in_word_t w;
    w = noise_word();
    w.action       = ACT_LOOKUP;
    w.lookup_vaddr = addr;
    w.span         = need;
    send(w);
  endtask

  // Drain every outstanding result, let the scan settle, then write the count
  task automatic set_active(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    active_shadow = v;
    settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_load();
    logic [31:0] base;
    logic [31:0] size;
    logic [31:0] foff;
    case ($urandom_range(0, 5))
      0:       base = 32'd0;
      1:       base = 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: base = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0:       size = 32'd0;
      1:       size = 32'hFFFF_FFFF;
      2:       size = $urandom_range(0, 64);
      default: size = $urandom >> $urandom_range(0, 31);
    endcase
    foff = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 15) : $urandom;
    load_entry($urandom_range(0, NUM_SEGMENTS - 1), base, size, foff);
  endtask

  // Mostly aim at an active entry, near and across its edges
  task automatic random_lookup();
    int          lim;
    int          k;
    logic [31:0] gap;
    logic [31:0] left;
    logic [31:0] need;
    lim = (active_shadow > NUM_SEGMENTS) ? NUM_SEGMENTS : active_shadow;
    if (lim == 0 || $urandom_range(0, 6) == 0) begin
      lookup($urandom, ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 255));
    end else begin
      k = $urandom_range(0, lim - 1);
      case ($urandom_range(0, 4))
        0:       gap = 32'd0;
        1:       gap = size_shadow[k];
        2:       gap = size_shadow[k] + 32'd1;
        default: gap = pick_upto(size_shadow[k]);
      endcase
      left = size_shadow[k] - gap;
      case ($urandom_range(0, 4))
        0:       need = 32'd0;
        1:       need = left;
        2:       need = left + 32'd1;
        3:       need = $urandom;
        default: need = pick_upto(left);
      endcase
      lookup(base_shadow[k] + gap, need);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] fixed_counts [7];
    int               phase_len;
    int               phase;
    fixed_counts  = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd15, 5'd17, 5'd8};
    words_sent    = 0;
    settings      = 0;
    active_shadow = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // count is zero after reset: every lookup misses
    lookup(32'd0, 32'd0);
    lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // fill the whole table before any entry can take part
    load_entry(0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0200);
    load_entry(1, 32'hFFFF_FF00, 32'h0000_00FF, 32'hFFFF_FFF0);
    load_entry(2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    load_entry(3, 32'h0000_1000, 32'h0000_1000, 32'h0000_5000);
    for (int i = 4; i < NUM_SEGMENTS - 1; i++)
      load_entry(i, $urandom, $urandom >> 8, $urandom);
    load_entry(NUM_SEGMENTS - 1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000);

    set_active(5'd16);
    lookup(32'h0000_1000, 32'd0);           // base of entry 0
    lookup(32'h0000_1100, 32'd0);           // distance equals size
    lookup(32'h0000_1101, 32'd0);           // just past entry 0, falls to entry 3
    lookup(32'h0000_1080, 32'h0000_0081);   // span one past room
    lookup(32'hFFFF_FFFF, 32'd0);           // file offset wraps
    lookup(32'h0000_0000, 32'd0);           // zero-size entry
    lookup(32'h0000_0000, 32'hFFFF_FFFF);   // full span, catch-all entry
    lookup(32'hFFFF_FFFF, 32'hFFFF_FFFF);

    set_active(5'd31);                      // saturates to table depth
    lookup(32'h0000_2000, 32'd16);
    set_active(5'd1);
    lookup(32'h0000_1101, 32'd0);

    phase = 0;
    while (words_sent < TOTAL_WORDS) begin
      if (phase < 7)
        set_active(fixed_counts[phase]);
      else
        set_active(CFG_W'($urandom_range(0, 31)));
      phase++;
      phase_len = $urandom_range(60, 100);
      for (int i = 0; i < phase_len && words_sent < TOTAL_WORDS; i++) begin
        if ($urandom_range(0, 9) < 3)
          random_load();
        else
          random_lookup();
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);

    $display("Sent %0d words over %0d active-count settings (0, 1, 16 and 31 among them).",
             words_sent, settings);
    $display("Checked %0d lookup results: %0d hits, %0d misses.", hits + misses, hits, misses);
    if (errors == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
